### src/csr_jacobi_sweep_macros.svh
// Assertion helpers for the sweep block
`ifndef CSR_JACOBI_SWEEP_MACROS_SVH
`define CSR_JACOBI_SWEEP_MACROS_SVH

`define CJS_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define CJS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/cjs_pkg.sv
`default_nettype none
package cjs_pkg;
    localparam int VectorSize = 1024;
    localparam int FracBits   = 16;
    localparam int VecAw      = $clog2(VectorSize);
    localparam int QueueDepth = 4;
    localparam int QueueAw    = $clog2(QueueDepth);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_ENTRY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // finished row handed from front to back
    typedef struct packed {
        logic [9:0]         row;
        logic signed [63:0] residual;
        logic signed [47:0] diag;
    } job_t;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_ACC
    } front_state_t;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } back_state_t;
endpackage
`default_nettype wire

### src/csr_jacobi_sweep.sv
`default_nettype none
// One Jacobi sweep over a CSR matrix in Q16.16. Load words fill the x store,
// a start word opens a row with its rhs, entry words accumulate. A load, a
// row start or a diagonal entry leaves the front idle; an off-diagonal entry
// goes through x read, multiply and saturating subtract before the next word.
// Finished rows pass a 4-deep queue to a restoring divider that takes one row
// at a time, so a stream of short rows is limited by the divider.
module csr_jacobi_sweep
    import cjs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         command,
    input  wire logic [9:0]         index,
    input  wire logic signed [31:0] value,
    input  wire logic               last_in_row,
    output logic                    empty,
    input  wire logic               pop,
    output logic [9:0]              row,
    output logic signed [31:0]      result_value,
    output logic [1:0]              status
);
    logic f_valid, f_ready, b_valid, b_ready;
    job_t f_job, b_job;

    cjs_front u_front (
        .clk, .rst_n, .push, .full, .command, .index, .value, .last_in_row,
        .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
    );

    cjs_queue u_queue (
        .clk, .rst_n,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
    );

    cjs_back u_back (
        .clk, .rst_n,
        .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
        .empty, .pop, .row, .result_value, .status
    );
endmodule
`default_nettype wire

### src/cjs_front.sv
`default_nettype none
module cjs_front
    import cjs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [1:0]         command,
    input  wire logic [9:0]         index,
    input  wire logic signed [31:0] value,
    input  wire logic               last_in_row,
    output logic                    job_valid,
    input  wire logic               job_ready,
    output job_t                    job
);
    logic [31:0] vec_mem [VectorSize];
    logic signed [31:0] xrd_reg;

    front_state_t state_reg, state_next;
    logic [9:0]         row_reg, row_next;
    logic signed [63:0] res_reg, res_next;
    logic signed [47:0] diag_reg, diag_next;
    logic signed [31:0] val_reg;
    logic               last_reg, xzero_reg;
    logic signed [63:0] prod_reg;
    logic               emit_reg, emit_next;
    logic               take;
    logic               is_diag;
    logic signed [47:0] diag_base;
    logic signed [48:0] dsum;
    logic signed [64:0] rdiff;

    assign full = (state_reg != FS_IDLE) || (emit_reg && !job_ready);
    assign take = push && !full;
    assign is_diag = (index == row_reg);
    assign job_valid = emit_reg;
    assign job = '{row: row_reg, residual: res_reg, diag: diag_reg};
    // a word taken while the finished row leaves starts from a cleared sum
    assign diag_base = emit_reg ? 48'sd0 : diag_reg;

    always_ff @(posedge clk)
    begin
        if (take && cmd_t'(command) == CMD_LOAD && 32'(index) < VectorSize)
        begin
            vec_mem[index[VecAw-1:0]] <= value;
        end
        if (take)
        begin
            xrd_reg <= vec_mem[index[VecAw-1:0]];
            xzero_reg <= !(32'(index) < VectorSize);
            val_reg <= value;
            last_reg <= last_in_row;
        end
        if (state_reg == FS_MUL)
        begin
            prod_reg <= xzero_reg ? 64'sd0 : 64'(val_reg) * 64'(xrd_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            row_reg   <= '0;
            res_reg   <= '0;
            diag_reg  <= '0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            res_reg   <= res_next;
            diag_reg  <= diag_next;
            emit_reg  <= emit_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        res_next   = res_reg;
        diag_next  = diag_reg;
        emit_next  = emit_reg;
        dsum  = 49'(diag_base) + 49'(value);
        rdiff = 65'(res_reg) - 65'(prod_reg);
        // clear sums once the finished row has been taken
        if (emit_reg && job_ready)
        begin
            emit_next = 1'b0;
            res_next  = '0;
            diag_next = '0;
        end
        unique case (state_reg)
            FS_IDLE:
            begin
                if (take)
                begin
                    unique case (cmd_t'(command))
                        CMD_START:
                        begin
                            row_next  = index;
                            res_next  = 64'(value) <<< FracBits;
                            diag_next = '0;
                            emit_next = last_in_row;
                        end
                        CMD_ENTRY:
                        begin
                            if (is_diag)
                            begin
                                if (dsum > 49'sh0_7FFF_FFFF_FFFF)
                                    diag_next = 48'sh7FFF_FFFF_FFFF;
                                else if (dsum < -49'sh0_8000_0000_0000)
                                    diag_next = 48'sh8000_0000_0000;
                                else
                                    diag_next = dsum[47:0];
                                emit_next = last_in_row;
                            end
                            else
                            begin
                                state_next = FS_MUL;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            FS_MUL:
            begin
                state_next = FS_ACC;
            end
            FS_ACC:
            begin
                if (rdiff[64] != rdiff[63])
                    res_next = rdiff[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                else
                    res_next = rdiff[63:0];
                emit_next  = last_reg;
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

`include "csr_jacobi_sweep_macros.svh"
    `CJS_ASSERT_IMPL(a_no_take_busy, state_reg != FS_IDLE, !take)
    `CJS_ASSERT_NEXT(a_mul_to_acc, state_reg == FS_MUL, state_reg == FS_ACC)
    `CJS_ASSERT_NEXT(a_emit_holds, emit_reg && !job_ready, emit_reg && $stable(row_reg))
endmodule
`default_nettype wire

### src/cjs_queue.sv
`default_nettype none
module cjs_queue
    import cjs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  job_t      wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);
    job_t slots_reg [QueueDepth];
    logic [QueueAw-1:0] wp_reg, rp_reg;
    logic [QueueAw:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (QueueAw+1)'(QueueDepth);
    assign rd_valid = cnt_reg != '0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = slots_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
            slots_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QueueAw+1)'(wr) - (QueueAw+1)'(rd);
        end
    end

`include "csr_jacobi_sweep_macros.svh"
    `CJS_ASSERT_IMPL(a_q_bound, 1'b1, cnt_reg <= (QueueAw+1)'(QueueDepth))
endmodule
`default_nettype wire

### src/cjs_back.sv
`default_nettype none
module cjs_back
    import cjs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  job_t                    job,
    output logic                    empty,
    input  wire logic               pop,
    output logic [9:0]              row,
    output logic signed [31:0]      result_value,
    output logic [1:0]              status
);
    back_state_t state_reg, state_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [47:0] den_reg;
    logic        neg_reg;
    logic [9:0]  row_reg;
    logic        zero_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic [9:0]  orow_reg;
    logic [31:0] oval_reg;
    logic [1:0]  ost_reg;
    logic        ofull_reg, ofull_next;
    logic [63:0] rmag;
    logic [47:0] dmag;
    logic [64:0] trial;
    logic [31:0] res_val;
    status_t     res_st;

    assign rmag = job.residual[63] ? 64'(-job.residual) : job.residual;
    assign dmag = job.diag[47] ? 48'(-job.diag) : job.diag;
    assign job_ready = (state_reg == BS_IDLE);
    assign empty = !ofull_reg;
    assign row = orow_reg;
    assign result_value = oval_reg;
    assign status = ost_reg;

    always_ff @(posedge clk)
    begin
        if (job_valid && job_ready)
        begin
            den_reg  <= dmag;
            neg_reg  <= job.residual[63] ^ job.diag[47];
            row_reg  <= job.row;
            zero_reg <= (job.diag == '0);
        end
        if (state_reg == BS_DONE && !ofull_reg)
        begin
            orow_reg <= row_reg;
            oval_reg <= res_val;
            ost_reg  <= res_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BS_IDLE;
            rem_reg   <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
            ofull_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
            ofull_reg <= ofull_next;
        end
    end

    // restoring divide, one quotient bit per cycle; result saturates to 32 bits, zero diag gives ST_ZERO
    always_comb
    begin
        trial = {rem_reg, quo_reg[63]} - {17'd0, den_reg};
        res_val = '0;
        res_st  = ST_OK;
        if (zero_reg)
        begin
            res_st = ST_ZERO;
        end
        else if (neg_reg)
        begin
            if (quo_reg > 64'h8000_0000)
            begin
                res_val = 32'h8000_0000;
                res_st  = ST_SAT;
            end
            else
            begin
                res_val = 32'(-quo_reg);
            end
        end
        else if (quo_reg > 64'h7FFF_FFFF)
        begin
            res_val = 32'h7FFF_FFFF;
            res_st  = ST_SAT;
        end
        else
        begin
            res_val = quo_reg[31:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        ofull_next = ofull_reg;
        if (ofull_reg && pop)
            ofull_next = 1'b0;
        unique case (state_reg)
            BS_IDLE:
            begin
                if (job_valid)
                begin
                    rem_next   = '0;
                    quo_next   = rmag;
                    cnt_next   = '0;
                    state_next = BS_DIV;
                end
            end
            BS_DIV:
            begin
                if (!trial[64])
                begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[62:0], quo_reg[63]};
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                    state_next = BS_DONE;
            end
            BS_DONE:
            begin
                if (!ofull_reg)
                begin
                    ofull_next = 1'b1;
                    state_next = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase
    end

`include "csr_jacobi_sweep_macros.svh"
    `CJS_ASSERT_NEXT(a_out_hold, ofull_reg && !pop, ofull_reg && $stable(oval_reg))
    `CJS_ASSERT_IMPL(a_cnt_idle, state_reg == BS_IDLE, cnt_reg == 7'd0 || cnt_reg == 7'd64)
endmodule
`default_nettype wire

### bench/csr_jacobi_sweep_tb.sv
`default_nettype none
module csr_jacobi_sweep_tb;
    import cjs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [9:0]  row;
        logic [31:0] val;
        logic [1:0]  st;
    } sweep_result_t;

    // directed row: optional typed-in result where it reads off at a glance
    typedef struct {
        cmd_t        cmd;
        logic [9:0]  idx;
        logic [31:0] val;
        logic        last;
        logic        has_fixed;
        logic [9:0]  fx_row;
        logic [31:0] fx_val;
        status_t     fx_st;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic [1:0] command = CMD_NONE;
    logic [9:0] index = '0;
    logic signed [31:0] value = '0;
    logic last_in_row = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic [9:0] row;
    logic signed [31:0] result_value;
    logic [1:0] status;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    bit errors = 1'b0;
    bit stim_done = 1'b0;

    sweep_result_t pending_rows[$];
    logic signed [31:0] x_model [0:VectorSize-1];
    bit x_loaded [0:VectorSize-1];
    logic [9:0] cur_row;
    logic signed [63:0] resid;
    logic signed [47:0] diag;

    always #4 clk = ~clk;

    csr_jacobi_sweep dut (.*);

    function automatic sweep_result_t close_row();
        sweep_result_t r;
        logic [63:0] mr, md, q;
        bit neg;
        r.row = cur_row;
        r.val = '0;
        r.st = ST_OK;
        if (diag == 0) begin
            r.st = ST_ZERO;
        end else begin
            mr = resid < 0 ? -resid : resid;
            md = diag < 0 ? -64'(diag) : 64'(diag);
            q = mr / md;
            neg = (resid < 0) != (diag < 0);
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    q = 64'h8000_0000;
                    r.st = ST_SAT;
                end
                r.val = 32'(-q);
            end else begin
                if (q > 64'h7FFF_FFFF) begin
                    q = 64'h7FFF_FFFF;
                    r.st = ST_SAT;
                end
                r.val = q[31:0];
            end
        end
        resid = '0;
        diag = '0;
        return r;
    endfunction

    // advance the predictor by one accepted word
    task automatic predict_word(input cmd_t c, input logic [9:0] i,
                                input logic signed [31:0] v, input logic l,
                                output bit has, output sweep_result_t r);
        logic signed [63:0] p, d64;
        logic signed [64:0] wide;
        has = 1'b0;
        case (c)
            CMD_LOAD:
            begin
                x_model[i] = v;
                x_loaded[i] = 1'b1;
            end
            CMD_START:
            begin
                cur_row = i;
                resid = 64'(v) <<< FracBits;
                diag = '0;
                if (l) begin
                    r = close_row();
                    has = 1'b1;
                end
            end
            CMD_ENTRY:
            begin
                if (i == cur_row) begin
                    d64 = 64'(diag) + 64'(v);
                    if (d64 > 64'sh0000_7FFF_FFFF_FFFF) d64 = 64'sh0000_7FFF_FFFF_FFFF;
                    if (d64 < -64'sh0000_8000_0000_0000) d64 = -64'sh0000_8000_0000_0000;
                    diag = d64[47:0];
                end else begin
                    p = 64'(v) * 64'(x_model[i]);
                    wide = 65'(resid) - 65'(p);
                    if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF) resid = 64'sh7FFF_FFFF_FFFF_FFFF;
                    else if (wide < -65'sh0_8000_0000_0000_0000)
                        resid = 64'sh8000_0000_0000_0000;
                    else resid = wide[63:0];
                end
                if (l) begin
                    r = close_row();
                    has = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input cmd_t c, input logic [9:0] i,
                             input logic signed [31:0] v, input logic l,
                             input bit fixed, input sweep_result_t fr);
        bit has;
        sweep_result_t r;
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        command <= c;
        index <= i;
        value <= v;
        last_in_row <= l;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_word(c, i, v, l, has, r);
        if (has) pending_rows.push_back(fixed ? fr : r);
    endtask

    task automatic release_push();
        push <= 1'b0;
        @(posedge clk);
    endtask

    // pick a loaded column or the row's own diagonal so no unwritten x is read
    function automatic logic [9:0] loaded_col();
        logic [9:0] c;
        c = 10'($urandom_range(15, 0));
        while (!x_loaded[c] && c != cur_row) c = 10'($urandom_range(15, 0));
        return c;
    endfunction

    task automatic random_row(input int n);
        sweep_result_t none;
        logic [9:0] r;
        int k;
        logic [31:0] v;
        r = 10'($urandom_range(15, 0));
        send_word(CMD_START, r, $urandom, n == 0, 1'b0, none);
        for (k = 0; k < n; k++) begin
            v = $urandom;
            if ($urandom_range(3, 0) == 0) v = 32'($signed(v) >>> 12);
            if ($urandom_range(2, 0) == 0)
                send_word(CMD_ENTRY, r, v, k == n - 1, 1'b0, none);
            else
                send_word(CMD_ENTRY, loaded_col(), v, k == n - 1, 1'b0, none);
        end
    endtask

    // receiver
    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            if (pending_rows.size() == 0) begin
                $display("%0t: unexpected result row %0d value %h status %0d",
                         $time, row, result_value, status);
                errors = 1'b1;
            end else begin
                if (pending_rows[0].row !== row || pending_rows[0].val !== result_value
                    || pending_rows[0].st !== status) begin
                    $display("%0t: mismatch expected row %0d value %h status %0d, actual row %0d value %h status %0d",
                             $time, pending_rows[0].row, pending_rows[0].val,
                             pending_rows[0].st, row, result_value, status);
                    errors = 1'b1;
                end
                void'(pending_rows.pop_front());
            end
        end
    end

    always @(posedge clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            pop <= 1'b0;
        end else begin
            pop <= !(recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
        end
    end

    initial begin
        #20ms;
        $display("csr_jacobi_sweep regression: fail");
        $finish;
    end

    initial begin
        stim_row_t dir[$];
        sweep_result_t fr, none;
        int n, ph, k, settle;
        dir = '{
            '{CMD_START, 10'd5, 32'h0001_0000, 1'b1, 1'b1, 10'd5, 32'h0, ST_ZERO},
            '{CMD_LOAD, 10'd0, 32'h0002_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_LOAD, 10'd1023, 32'h8000_0000, 1'b1, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_LOAD, 10'd1, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_NONE, 10'h3FF, 32'hFFFF_FFFF, 1'b1, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_START, 10'd2, 32'h0004_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd2, 32'h0002_0000, 1'b1, 1'b1, 10'd2, 32'h0002_0000, ST_OK},
            '{CMD_START, 10'd3, 32'h0001_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd0, 32'h0001_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd3, 32'h0001_0000, 1'b1, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_START, 10'd4, 32'h7FFF_FFFF, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd4, 32'h0000_0001, 1'b1, 1'b1, 10'd4, 32'h7FFF_FFFF, ST_SAT},
            '{CMD_START, 10'd6, 32'h8000_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd6, 32'h0000_0001, 1'b1, 1'b1, 10'd6, 32'h8000_0000, ST_SAT},
            '{CMD_START, 10'd1023, 32'h0, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd1, 32'h8000_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd1023, 32'h8000_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd1023, 32'h7FFF_FFFF, 1'b1, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_START, 10'd7, 32'h0001_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_START, 10'd8, 32'h0003_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd8, 32'h0, 1'b1, 1'b1, 10'd8, 32'h0, ST_ZERO},
            '{CMD_ENTRY, 10'd0, 32'h0001_0000, 1'b0, 1'b0, 10'd0, 32'h0, ST_OK},
            '{CMD_ENTRY, 10'd0, 32'hFFFF_0000, 1'b1, 1'b0, 10'd0, 32'h0, ST_OK}
        };
        for (k = 0; k < VectorSize; k++) begin
            x_model[k] = '0;
            x_loaded[k] = 1'b0;
        end
        cur_row = '0;
        resid = '0;
        diag = '0;
        none = '{default: '0};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir[k]) begin
            fr = '{dir[k].fx_row, dir[k].fx_val, dir[k].fx_st};
            send_word(dir[k].cmd, dir[k].idx, dir[k].val, dir[k].last,
                      dir[k].has_fixed, fr);
        end
        for (k = 0; k < 16; k++) send_word(CMD_LOAD, 10'(k), $urandom, 1'b0, 1'b0, none);
        release_push();

        // long receiver hold-off while the sender keeps pushing
        hold_off_cycles = 400;
        for (k = 0; k < 10; k++) random_row(1);
        release_push();

        n = 0;
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 74 : 18) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 74 : 18) : 0;
            while (n < 130 * (ph + 1)) begin
                case ($urandom_range(9, 0))
                    0: begin
                        send_word(CMD_LOAD, 10'($urandom), $urandom, 1'($urandom), 1'b0,
                                  none);
                        x_loaded[index] = 1'b1;
                        n++;
                    end
                    1: begin
                        send_word(CMD_LOAD, 10'($urandom_range(15, 0)), $urandom,
                                  1'b0, 1'b0, none);
                        n++;
                    end
                    2: begin
                        send_word(CMD_NONE, 10'($urandom), $urandom, 1'($urandom), 1'b0,
                                  none);
                    end
                    3: begin
                        // dropped row: restart before finishing
                        send_word(CMD_START, 10'($urandom), $urandom, 1'b0, 1'b0, none);
                        send_word(CMD_ENTRY, loaded_col(), $urandom, 1'b0, 1'b0, none);
                        n += 2;
                    end
                    default: begin
                        k = $urandom_range(4, 0);
                        random_row(k);
                        n += k + 1;
                    end
                endcase
            end
            release_push();
            while (pending_rows.size() != 0) @(posedge clk);
        end
        recv_stall_pct = 0;
        stim_done = 1'b1;
        settle = 0;
        while (pending_rows.size() != 0 && settle < 100000) begin
            @(posedge clk);
            settle++;
        end
        repeat (300) @(posedge clk);
        if (!errors && pending_rows.size() == 0) begin
            $display("csr_jacobi_sweep regression: pass");
        end else begin
            if (pending_rows.size() != 0)
                $display("%0t: %0d results never arrived", $time, pending_rows.size());
            $display("csr_jacobi_sweep regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
